// ----- rtl/core/atom_pair_clash_energy_macros.svh -----
// Assertion macros shared by the clash energy RTL.
`ifndef ATOM_PAIR_CLASH_ENERGY_MACROS_SVH
`define ATOM_PAIR_CLASH_ENERGY_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define APCE_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset.
`define APCE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/apce_pkg.sv -----
// Package with widths, codes and types of the atom pair clash energy block.
package apce_pkg;

   localparam int COORD_W    = 20;
   localparam int MAG_W      = COORD_W + 1;
   localparam int REG_W      = 12;
   localparam int SLOT_W     = 2;
   localparam int ENERGY_W   = 24;
   localparam int SQ_W       = 2 * REG_W;
   localparam int DIST2_W    = SQ_W + 2;
   localparam int DIGIT_W    = 4;
   localparam int PART_W     = REG_W + DIGIT_W;
   localparam int SQ_STEPS   = REG_W / DIGIT_W;
   localparam int ROOT_STEPS = REG_W;
   localparam int REM_W      = REG_W + 3;
   localparam int CNT_W      = 4;
   localparam int CSR_IDX_W  = 3;

   localparam int ATOMS_PER_RESIDUE = 3;

   localparam logic [ENERGY_W-1:0] ENERGY_MAX = '1;

   localparam logic [SLOT_W-1:0] SLOT_BACKBONE = 2'd0;
   localparam logic [SLOT_W-1:0] SLOT_ONE      = 2'd1;

   localparam logic [REG_W-1:0] RST_SLOT0_CUTOFF = 12'd1280;
   localparam logic [REG_W-1:0] RST_SLOT0_CENTER = 12'd1024;
   localparam logic [REG_W-1:0] RST_SLOT1_CUTOFF = 12'd1280;
   localparam logic [REG_W-1:0] RST_SLOT1_CENTER = 12'd1280;
   localparam logic [REG_W-1:0] RST_OTHER_CUTOFF = 12'd896;
   localparam logic [REG_W-1:0] RST_OTHER_CENTER = 12'd896;

   localparam logic [CSR_IDX_W-1:0] IDX_SLOT0_CUTOFF = 3'd0;
   localparam logic [CSR_IDX_W-1:0] IDX_SLOT0_CENTER = 3'd1;
   localparam logic [CSR_IDX_W-1:0] IDX_SLOT1_CUTOFF = 3'd2;
   localparam logic [CSR_IDX_W-1:0] IDX_SLOT1_CENTER = 3'd3;
   localparam logic [CSR_IDX_W-1:0] IDX_OTHER_CUTOFF = 3'd4;
   localparam logic [CSR_IDX_W-1:0] IDX_OTHER_CENTER = 3'd5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_COMPARE,
      ST_ROOT,
      ST_DIFF,
      ST_DIFF_SQ,
      ST_ACCUM
   } state_type;

   typedef struct packed {
      logic [REG_W-1:0] cutoff;
      logic [REG_W-1:0] center;
   } thresh_type;

   typedef struct packed {
      logic load;
      logic step;
   } unit_ctrl_type;

endpackage

// ----- rtl/core/apce_ifs.sv -----
// Handshake interfaces for the pair, result and register write channels.
interface apce_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [apce_pkg::COORD_W-1:0]  ax;
   logic signed [apce_pkg::COORD_W-1:0]  ay;
   logic signed [apce_pkg::COORD_W-1:0]  az;
   logic signed [apce_pkg::COORD_W-1:0]  bx;
   logic signed [apce_pkg::COORD_W-1:0]  by;
   logic signed [apce_pkg::COORD_W-1:0]  bz;
   logic        [apce_pkg::SLOT_W-1:0]   first_slot;
   logic        [apce_pkg::SLOT_W-1:0]   second_slot;
   logic                                 last_pair;

   modport source (output valid, ax, ay, az, bx, by, bz, first_slot, second_slot, last_pair,
                   input ready);
   modport sink   (input valid, ax, ay, az, bx, by, bz, first_slot, second_slot, last_pair,
                   output ready);
endinterface

interface apce_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [apce_pkg::ENERGY_W-1:0]    energy;
   logic                             saturated;

   modport source (output valid, energy, saturated, input ready);
   modport sink   (input valid, energy, saturated, output ready);
endinterface

interface apce_csr_if;
   logic                              valid;
   logic                              ready;
   logic [apce_pkg::CSR_IDX_W-1:0]    index;
   logic [apce_pkg::REG_W-1:0]        data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/core/atom_pair_clash_energy.sv -----
// Top level of the atom pair clash energy accumulator.
// One atom pair word is taken at a time. A pair whose distance falls below the
// cutoff of its slot class passes, from acceptance to readiness for the next
// word, through the accept, 4-bit-digit squaring of the axis deltas and the
// cutoff, a compare, the restoring square root (one root bit per cycle), the
// forming of |d - center|, digit squaring of it and an accumulate. A pair
// outside the cutoff goes from accept through squaring and compare to the
// accumulate. A pair marked last holds in the accumulate cycle only while the
// previous result word has not been taken; the result sits in an output
// register, so new pair words are accepted while it waits. Energy is Q16 and
// clamps at all ones, with the saturated flag set; the total and flag clear
// once the result word is loaded.
`include "atom_pair_clash_energy_macros.svh"

module atom_pair_clash_energy (
   input  logic       clock,
   input  logic       reset,
   apce_req_if.sink   req_port,
   apce_rsp_if.source rsp_port,
   apce_csr_if.sink   csr_port
);

   // Absolute difference of two signed coordinates, one bit wider.
   function automatic logic [apce_pkg::MAG_W-1:0] abs_diff(
      input logic signed [apce_pkg::COORD_W-1:0] a,
      input logic signed [apce_pkg::COORD_W-1:0] b
   );
      logic signed [apce_pkg::MAG_W-1:0] d;
      d = apce_pkg::MAG_W'(a) - apce_pkg::MAG_W'(b);
      return d[apce_pkg::MAG_W-1] ? apce_pkg::MAG_W'(-d) : apce_pkg::MAG_W'(d);
   endfunction

   apce_pkg::state_type         state_ff, state_in;
   logic [apce_pkg::CNT_W-1:0]  cnt_ff, cnt_in;

   apce_pkg::thresh_type        thresh;
   apce_pkg::unit_ctrl_type     axis_ctrl, aux_ctrl, root_ctrl;

   logic [apce_pkg::MAG_W-1:0]  mag_x, mag_y, mag_z;
   logic                        far_now;
   logic [apce_pkg::REG_W-1:0]  aux_operand, diff, root;
   logic [apce_pkg::SQ_W-1:0]   prod_x, prod_y, prod_z, prod_aux;
   logic [apce_pkg::DIST2_W-1:0] dist2;
   logic                        hit_now;

   logic                        last_ff, far_ff, hit_ff;
   logic [apce_pkg::REG_W-1:0]  cutoff_ff, center_ff;

   logic [apce_pkg::ENERGY_W-1:0] energy_sum_ff, add_term, sum_next;
   logic [apce_pkg::ENERGY_W:0]   total;
   logic                          sum_clipped_ff, clip_next;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [apce_pkg::ENERGY_W-1:0] rsp_energy_ff;
   logic                          rsp_sat_ff;

   logic accept, slot_free, publish, fold;

   // ---------------------------------------------------------------------
   // Register file and class selection off the incoming word's slots
   // ---------------------------------------------------------------------
   apce_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_port    (csr_port),
      .first_slot  (req_port.first_slot),
      .second_slot (req_port.second_slot),
      .thresh      (thresh)
   );

   // ---------------------------------------------------------------------
   // Axis magnitudes. Any delta of 4096 (16 A) or more puts the squared
   // distance past every 12-bit cutoff squared, so only the low 12 bits
   // go to the squaring lanes and the rest becomes a far flag.
   // ---------------------------------------------------------------------
   assign mag_x   = abs_diff(req_port.ax, req_port.bx);
   assign mag_y   = abs_diff(req_port.ay, req_port.by);
   assign mag_z   = abs_diff(req_port.az, req_port.bz);
   assign far_now = (|mag_x[apce_pkg::MAG_W-1:apce_pkg::REG_W]) |
                    (|mag_y[apce_pkg::MAG_W-1:apce_pkg::REG_W]) |
                    (|mag_z[apce_pkg::MAG_W-1:apce_pkg::REG_W]);

   assign accept = req_port.valid && req_port.ready;

   // ---------------------------------------------------------------------
   // Squaring lanes: three axis lanes and one auxiliary lane that squares
   // the cutoff first and |d - center| later.
   // ---------------------------------------------------------------------
   apce_sq_lane u_sq_x (
      .clock (clock), .ctrl (axis_ctrl),
      .operand (mag_x[apce_pkg::REG_W-1:0]), .product (prod_x)
   );
   apce_sq_lane u_sq_y (
      .clock (clock), .ctrl (axis_ctrl),
      .operand (mag_y[apce_pkg::REG_W-1:0]), .product (prod_y)
   );
   apce_sq_lane u_sq_z (
      .clock (clock), .ctrl (axis_ctrl),
      .operand (mag_z[apce_pkg::REG_W-1:0]), .product (prod_z)
   );

   assign aux_operand = (state_ff == apce_pkg::ST_DIFF) ? diff : thresh.cutoff;

   apce_sq_lane u_sq_aux (
      .clock (clock), .ctrl (aux_ctrl),
      .operand (aux_operand), .product (prod_aux)
   );

   // Floor of the distance below the cutoff iff dist2 below cutoff squared.
   assign dist2   = apce_pkg::DIST2_W'(prod_x) + apce_pkg::DIST2_W'(prod_y) +
                    apce_pkg::DIST2_W'(prod_z);
   assign hit_now = !far_ff && (dist2 < apce_pkg::DIST2_W'(prod_aux));

   // A hit guarantees dist2 fits in 24 bits.
   apce_isqrt u_isqrt (
      .clock    (clock),
      .ctrl     (root_ctrl),
      .radicand (dist2[apce_pkg::SQ_W-1:0]),
      .root     (root)
   );

   assign diff = (root >= center_ff) ? (root - center_ff) : (center_ff - root);

   // ---------------------------------------------------------------------
   // Saturating accumulate
   // ---------------------------------------------------------------------
   assign add_term  = hit_ff ? prod_aux : '0;
   assign total     = (apce_pkg::ENERGY_W + 1)'(energy_sum_ff) +
                      (apce_pkg::ENERGY_W + 1)'(add_term);
   assign sum_next  = total[apce_pkg::ENERGY_W] ? apce_pkg::ENERGY_MAX
                                                : total[apce_pkg::ENERGY_W-1:0];
   assign clip_next = sum_clipped_ff | total[apce_pkg::ENERGY_W];

   // Result register is free when empty or once its word is taken this cycle.
   assign slot_free = !rsp_valid_ff || rsp_port.ready;

   // ---------------------------------------------------------------------
   // Sequencer: next state
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         apce_pkg::ST_IDLE: begin
            if (accept) state_in = apce_pkg::ST_SQUARE;
         end
         apce_pkg::ST_SQUARE: begin
            if (cnt_ff == apce_pkg::CNT_W'(apce_pkg::SQ_STEPS - 1))
               state_in = apce_pkg::ST_COMPARE;
         end
         apce_pkg::ST_COMPARE: begin
            state_in = hit_now ? apce_pkg::ST_ROOT : apce_pkg::ST_ACCUM;
         end
         apce_pkg::ST_ROOT: begin
            if (cnt_ff == apce_pkg::CNT_W'(apce_pkg::ROOT_STEPS - 1))
               state_in = apce_pkg::ST_DIFF;
         end
         apce_pkg::ST_DIFF: begin
            state_in = apce_pkg::ST_DIFF_SQ;
         end
         apce_pkg::ST_DIFF_SQ: begin
            if (cnt_ff == apce_pkg::CNT_W'(apce_pkg::SQ_STEPS - 1))
               state_in = apce_pkg::ST_ACCUM;
         end
         apce_pkg::ST_ACCUM: begin
            if (!last_ff || slot_free) state_in = apce_pkg::ST_IDLE;
         end
         default: state_in = apce_pkg::ST_IDLE;
      endcase
      // restart the step count on every state change
      cnt_in = (state_in != state_ff) ? '0 : cnt_ff + apce_pkg::CNT_W'(1);
   end

   // ---------------------------------------------------------------------
   // Sequencer: outputs
   // ---------------------------------------------------------------------
   always_comb begin
      req_port.ready = 1'b0;
      axis_ctrl      = '0;
      aux_ctrl       = '0;
      root_ctrl      = '0;
      fold           = 1'b0;
      unique case (state_ff)
         apce_pkg::ST_IDLE: begin
            req_port.ready = 1'b1;
            axis_ctrl.load = accept;
            aux_ctrl.load  = accept;
         end
         apce_pkg::ST_SQUARE: begin
            axis_ctrl.step = 1'b1;
            aux_ctrl.step  = 1'b1;
         end
         apce_pkg::ST_COMPARE: begin
            root_ctrl.load = 1'b1;
         end
         apce_pkg::ST_ROOT: begin
            root_ctrl.step = 1'b1;
         end
         apce_pkg::ST_DIFF: begin
            aux_ctrl.load = 1'b1;
         end
         apce_pkg::ST_DIFF_SQ: begin
            aux_ctrl.step = 1'b1;
         end
         apce_pkg::ST_ACCUM: begin
            fold = !last_ff || slot_free;
         end
         default: ;
      endcase
   end

   assign publish      = fold && last_ff;
   assign rsp_valid_in = (rsp_valid_ff && !rsp_port.ready) || publish;

   // ---------------------------------------------------------------------
   // Control and accumulator registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= apce_pkg::ST_IDLE;
         cnt_ff         <= '0;
         energy_sum_ff  <= '0;
         sum_clipped_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         hit_ff         <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == apce_pkg::ST_COMPARE) hit_ff <= hit_now;
         if (publish) begin
            // clear the total once it leaves in the result word
            energy_sum_ff  <= '0;
            sum_clipped_ff <= 1'b0;
         end else if (fold) begin
            energy_sum_ff  <= sum_next;
            sum_clipped_ff <= clip_next;
         end
      end
   end

   // Per-word payload: hold the pair's flags and thresholds, and the result word on publish.
   always_ff @(posedge clock) begin
      if (accept) begin
         last_ff   <= req_port.last_pair;
         far_ff    <= far_now;
         cutoff_ff <= thresh.cutoff;
         center_ff <= thresh.center;
      end
      if (publish) begin
         rsp_energy_ff <= sum_next;
         rsp_sat_ff    <= clip_next;
      end
   end

   assign rsp_port.valid     = rsp_valid_ff;
   assign rsp_port.energy    = rsp_energy_ff;
   assign rsp_port.saturated = rsp_sat_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   `APCE_ASSERT_NOW(a_root_only_on_hit, state_ff == apce_pkg::ST_ROOT, hit_ff, "root pass without a hit")
   `APCE_ASSERT_NOW(a_root_below_cutoff, state_ff == apce_pkg::ST_DIFF, root < cutoff_ff, "root not below cutoff")
   `APCE_ASSERT_NOW(a_clip_means_max, sum_clipped_ff, energy_sum_ff == apce_pkg::ENERGY_MAX, "clipped sum not at max")
   `APCE_ASSERT_NEXT(a_clear_after_result, publish, (energy_sum_ff == '0) && !sum_clipped_ff && rsp_valid_ff, "total not cleared")

endmodule

// ----- rtl/core/apce_csr.sv -----
// Threshold register file with slot class selection.
module apce_csr (
   input  logic                            clock,
   input  logic                            reset,
   apce_csr_if.sink                        csr_port,
   input  logic [apce_pkg::SLOT_W-1:0]     first_slot,
   input  logic [apce_pkg::SLOT_W-1:0]     second_slot,
   output apce_pkg::thresh_type            thresh
);

   logic [apce_pkg::REG_W-1:0] slot0_cutoff_ff, slot0_center_ff;
   logic [apce_pkg::REG_W-1:0] slot1_cutoff_ff, slot1_center_ff;
   logic [apce_pkg::REG_W-1:0] other_cutoff_ff, other_center_ff;
   logic                       is_slot0, is_slot1;

   assign csr_port.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         slot0_cutoff_ff <= apce_pkg::RST_SLOT0_CUTOFF;
         slot0_center_ff <= apce_pkg::RST_SLOT0_CENTER;
         slot1_cutoff_ff <= apce_pkg::RST_SLOT1_CUTOFF;
         slot1_center_ff <= apce_pkg::RST_SLOT1_CENTER;
         other_cutoff_ff <= apce_pkg::RST_OTHER_CUTOFF;
         other_center_ff <= apce_pkg::RST_OTHER_CENTER;
      end else if (csr_port.valid) begin
         // drop writes beyond the last register
         unique case (csr_port.index)
            apce_pkg::IDX_SLOT0_CUTOFF: slot0_cutoff_ff <= csr_port.data;
            apce_pkg::IDX_SLOT0_CENTER: slot0_center_ff <= csr_port.data;
            apce_pkg::IDX_SLOT1_CUTOFF: slot1_cutoff_ff <= csr_port.data;
            apce_pkg::IDX_SLOT1_CENTER: slot1_center_ff <= csr_port.data;
            apce_pkg::IDX_OTHER_CUTOFF: other_cutoff_ff <= csr_port.data;
            apce_pkg::IDX_OTHER_CENTER: other_center_ff <= csr_port.data;
            default: ;
         endcase
      end
   end

   assign is_slot0 = (first_slot == apce_pkg::SLOT_BACKBONE) ||
                     (second_slot == apce_pkg::SLOT_BACKBONE);
   assign is_slot1 = (first_slot == apce_pkg::SLOT_ONE) ||
                     (second_slot == apce_pkg::SLOT_ONE);

   always_comb begin
      if (is_slot0) begin
         thresh.cutoff = slot0_cutoff_ff;
         thresh.center = slot0_center_ff;
      end else if (is_slot1) begin
         thresh.cutoff = slot1_cutoff_ff;
         thresh.center = slot1_center_ff;
      end else begin
         thresh.cutoff = other_cutoff_ff;
         thresh.center = other_center_ff;
      end
   end

endmodule

// ----- rtl/core/apce_sq_lane.sv -----
// Digit-serial squaring lane: one 4-bit multiplier digit per step, MSB first.
module apce_sq_lane (
   input  logic                            clock,
   input  apce_pkg::unit_ctrl_type         ctrl,
   input  logic [apce_pkg::REG_W-1:0]      operand,
   output logic [apce_pkg::SQ_W-1:0]       product
);

   logic [apce_pkg::REG_W-1:0]  mcand_ff, mplier_ff, mplier_in;
   logic [apce_pkg::SQ_W-1:0]   prod_ff, prod_in;
   logic [apce_pkg::PART_W-1:0] partial;

   assign partial   = apce_pkg::PART_W'(mcand_ff) *
                      apce_pkg::PART_W'(mplier_ff[apce_pkg::REG_W-1 -: apce_pkg::DIGIT_W]);
   assign prod_in   = {prod_ff[apce_pkg::SQ_W-apce_pkg::DIGIT_W-1:0],
                       apce_pkg::DIGIT_W'(0)} + apce_pkg::SQ_W'(partial);
   assign mplier_in = {mplier_ff[apce_pkg::REG_W-apce_pkg::DIGIT_W-1:0],
                       apce_pkg::DIGIT_W'(0)};

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         mcand_ff  <= operand;
         mplier_ff <= operand;
         prod_ff   <= '0;
      end else if (ctrl.step) begin
         mplier_ff <= mplier_in;
         prod_ff   <= prod_in;
      end
   end

   assign product = prod_ff;

endmodule

// ----- rtl/core/apce_isqrt.sv -----
// Restoring square root: one root bit per step from a 24-bit radicand.
module apce_isqrt (
   input  logic                            clock,
   input  apce_pkg::unit_ctrl_type         ctrl,
   input  logic [apce_pkg::SQ_W-1:0]       radicand,
   output logic [apce_pkg::REG_W-1:0]      root
);

   logic [apce_pkg::SQ_W-1:0]  rad_ff;
   logic [apce_pkg::REM_W-1:0] rem_ff, rem_in, rem_sh, trial;
   logic [apce_pkg::REG_W-1:0] root_ff, root_in;
   logic                       fits;

   always_comb begin
      // bring down the next two radicand bits, try root*4+1
      rem_sh  = {rem_ff[apce_pkg::REM_W-3:0], rad_ff[apce_pkg::SQ_W-1 -: 2]};
      trial   = {1'b0, root_ff, 2'b01};
      fits    = (rem_sh >= trial);
      rem_in  = fits ? (rem_sh - trial) : rem_sh;
      root_in = {root_ff[apce_pkg::REG_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         rad_ff  <= radicand;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (ctrl.step) begin
         rad_ff  <= {rad_ff[apce_pkg::SQ_W-3:0], 2'b00};
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign root = root_ff;

endmodule
